// ----- rtl/qtc_pkg.sv -----
// shared constants for the quintic trajectory coefficient solver
// no dependencies
package qtc_pkg;

  localparam int DATA_WIDTH_DEF     = 32;
  localparam int COEF_FRAC_BITS_DEF = 32;

  localparam int FIELD_W  = 32;  // boundary condition fields, q16.16
  localparam int TAU_W    = 24;  // duration field, q8.16
  localparam int TAU_FRAC = 16;
  localparam int COEF_W   = 64;

  // register stages ahead of the dividers and inside one divider
  localparam int FRONT_LAT = 7;
  localparam int DIV_LAT   = COEF_W + 2;

endpackage

// ----- rtl/qtc_if.sv -----
// valid/ready channels for axis requests and coefficient results
// depends on qtc_pkg
interface qtc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [qtc_pkg::FIELD_W-1:0]     start_position;
  logic signed [qtc_pkg::FIELD_W-1:0]     start_velocity;
  logic signed [qtc_pkg::FIELD_W-1:0]     start_acceleration;
  logic signed [qtc_pkg::FIELD_W-1:0]     end_position;
  logic signed [qtc_pkg::FIELD_W-1:0]     end_velocity;
  logic signed [qtc_pkg::FIELD_W-1:0]     end_acceleration;
  logic        [qtc_pkg::TAU_W-1:0]       duration;

  modport source(output valid, start_position, start_velocity, start_acceleration,
                 end_position, end_velocity, end_acceleration, duration, input ready);
  modport sink(input valid, start_position, start_velocity, start_acceleration,
               end_position, end_velocity, end_acceleration, duration, output ready);
endinterface

interface qtc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qtc_pkg::COEF_W-1:0]  coef_pow5;
  logic signed [qtc_pkg::COEF_W-1:0]  coef_pow4;
  logic signed [qtc_pkg::COEF_W-1:0]  coef_pow3;
  logic signed [qtc_pkg::COEF_W-1:0]  coef_pow2;
  logic signed [qtc_pkg::COEF_W-1:0]  coef_pow1;
  logic signed [qtc_pkg::COEF_W-1:0]  coef_pow0;
  logic                               singular_flag;
  logic                               saturated_flag;

  modport source(output valid, coef_pow5, coef_pow4, coef_pow3, coef_pow2, coef_pow1,
                 coef_pow0, singular_flag, saturated_flag, input ready);
  modport sink(input valid, coef_pow5, coef_pow4, coef_pow3, coef_pow2, coef_pow1,
               coef_pow0, singular_flag, saturated_flag, output ready);
endinterface

// ----- rtl/qtc_div.sv -----
// pipelined restoring divider, one quotient bit per stage, rounded and clamped
// depends on qtc_pkg
module qtc_div #(
  parameter int NUM_W = 89,
  parameter int SHIFT = 32,
  parameter int DEN_W = 73
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [NUM_W-1:0]             num_mag,
  input  logic                         num_neg,
  input  logic [DEN_W-1:0]             den,
  output logic [qtc_pkg::COEF_W-1:0]   quo,
  output logic                         sat
);

  localparam int QB   = qtc_pkg::COEF_W;
  localparam int XW   = NUM_W + SHIFT;
  localparam int HW   = XW - QB;
  localparam int CMPW = (HW > DEN_W) ? HW : DEN_W;

  logic [DEN_W-1:0] rem_r [QB+1];
  logic [QB-1:0]    quo_r [QB+1];
  logic [QB-1:0]    xlo_r [QB+1];
  logic [DEN_W-1:0] den_r [QB+1];
  logic             neg_r [QB+1];
  logic             ovf_r [QB+1];

  logic [XW-1:0]    x;
  logic [HW-1:0]    x_hi;
  logic             ovf;

  assign x    = {num_mag, {SHIFT{1'b0}}};
  assign x_hi = x[XW-1:QB];
  // quotient would need more than the result bits
  assign ovf  = CMPW'(x_hi) >= CMPW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DEN_W'(x_hi);
      quo_r[0] <= '0;
      xlo_r[0] <= x[QB-1:0];
      den_r[0] <= den;
      neg_r[0] <= num_neg;
      ovf_r[0] <= ovf;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [DEN_W:0] rs;
    logic [DEN_W:0] diff;
    logic           ge;

    assign rs   = {rem_r[i-1], xlo_r[i-1][QB-1]};
    assign diff = rs - {1'b0, den_r[i-1]};
    assign ge   = rs >= {1'b0, den_r[i-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
        quo_r[i] <= {quo_r[i-1][QB-2:0], ge};
        xlo_r[i] <= {xlo_r[i-1][QB-2:0], 1'b0};
        den_r[i] <= den_r[i-1];
        neg_r[i] <= neg_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
      end
    end
  end

  // round half away from zero on the magnitude, then clamp and restore sign
  logic          rnd;
  logic [QB:0]   q1;
  logic [QB:0]   limit;
  logic          sat_nxt;
  logic [QB-1:0] res;
  logic [QB-1:0] quo_nxt;
  logic [QB-1:0] quo_out_r;
  logic          sat_r;

  always_comb begin
    rnd     = {rem_r[QB], 1'b0} >= {1'b0, den_r[QB]};
    q1      = {1'b0, quo_r[QB]} + (QB+1)'(rnd);
    limit   = neg_r[QB] ? ((QB+1)'(1) << (QB-1)) : (((QB+1)'(1) << (QB-1)) - (QB+1)'(1));
    sat_nxt = ovf_r[QB] || (q1 > limit);
    res     = sat_nxt ? limit[QB-1:0] : q1[QB-1:0];
    quo_nxt = neg_r[QB] ? (~res + QB'(1)) : res;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_out_r <= quo_nxt;
      sat_r     <= sat_nxt;
    end
  end

  assign quo = quo_out_r;
  assign sat = sat_r;

endmodule

// ----- rtl/quintic_trajectory_coefficients.sv -----
// quintic trajectory coefficient solver, top level
// depends on qtc_pkg, qtc_if and qtc_div

// One axis per transfer: start/end position, velocity, acceleration (q16.16)
// and a duration T (unsigned q8.16) go in; the six coefficients of the quintic
// that meets all boundary conditions come out, highest power first, signed with
// COEF_FRAC_BITS fraction bits (q32.32 by default), each rounded once to nearest
// with ties away from zero. A new axis is taken every clock cycle unless the
// result side stalls. The numerator products and the powers T^3..T^5 are formed
// in the front stages, then the bit-per-stage quotient pipelines divide by
// 2T^3, 2T^4 and 2T^5 (one quotient bit per stage).
// A stall on the result side holds the whole pipeline, nothing is dropped.
// T = 0 sets singular_flag, zeroes the t^5, t^4 and t^3 coefficients and still
// reports the start terms. A coefficient that does not fit 64 bits is clamped
// and saturated_flag is set.
module quintic_trajectory_coefficients #(
  parameter int DATA_WIDTH     = qtc_pkg::DATA_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = qtc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  qtc_in_if.sink       in_ch,
  qtc_out_if.source    out_ch
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = COEF_FRAC_BITS;
  localparam int TW   = qtc_pkg::TAU_W;
  localparam int TF   = qtc_pkg::TAU_FRAC;
  localparam int CWD  = qtc_pkg::COEF_W;
  localparam int CW   = W + 7;              // combined boundary terms
  localparam int PW   = CW + TW + 1;        // term times a 24-bit chunk
  localparam int NW   = CW + 2 * TW + 1;    // full numerator
  localparam int LAT  = qtc_pkg::FRONT_LAT + qtc_pkg::DIV_LAT;

  typedef struct packed {
    logic signed [CWD-1:0] c2;
    logic signed [CWD-1:0] c1;
    logic signed [CWD-1:0] c0;
    logic                  sing;
  } sb_t;

  logic vld_r [LAT];
  sb_t  sb_r  [LAT];
  sb_t  sb_nxt;

  logic en;

  // pipeline moves whenever the result register is free or being drained
  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage 1: sign extension and combined terms
  logic signed [W-1:0] p0w, v0w, a0w, p1w, v1w, a1w;
  assign p0w = $signed(in_ch.start_position[W-1:0]);
  assign v0w = $signed(in_ch.start_velocity[W-1:0]);
  assign a0w = $signed(in_ch.start_acceleration[W-1:0]);
  assign p1w = $signed(in_ch.end_position[W-1:0]);
  assign v1w = $signed(in_ch.end_velocity[W-1:0]);
  assign a1w = $signed(in_ch.end_acceleration[W-1:0]);

  logic signed [CWD-1:0] c2_full;
  // a0 / 2 at the output scale, exact unless no fraction bit is left over
  if (COEF_FRAC_BITS > TF) begin : g_c2_shift
    assign c2_full = CWD'(a0w) <<< (F - TF - 1);
  end else begin : g_c2_round
    assign c2_full = (a0w >= 0) ? ((CWD'(a0w) + CWD'(1)) >>> 1) : (CWD'(a0w) >>> 1);
  end

  logic signed [CW-1:0] h, p0c, v0c, a0c, p1c, v1c, a1c;
  logic signed [CW-1:0] cc_nxt [3];
  logic signed [CW-1:0] dd_nxt [3];
  logic signed [CW-1:0] ee_nxt [3];
  logic [2*TW-1:0]      tau2_nxt;

  always_comb begin
    p0c = CW'(p0w);
    v0c = CW'(v0w);
    a0c = CW'(a0w);
    p1c = CW'(p1w);
    v1c = CW'(v1w);
    a1c = CW'(a1w);
    h   = p1c - p0c;
    // index 0: t^3 numerator, 1: t^4, 2: t^5
    cc_nxt[0] = CW'(20 * h);
    dd_nxt[0] = CW'(-(8 * v1c + 12 * v0c));
    ee_nxt[0] = CW'(-(3 * a0c - a1c));
    cc_nxt[1] = CW'(-30 * h);
    dd_nxt[1] = CW'(14 * v1c + 16 * v0c);
    ee_nxt[1] = CW'(3 * a0c - 2 * a1c);
    cc_nxt[2] = CW'(12 * h);
    dd_nxt[2] = CW'(-6 * (v1c + v0c));
    ee_nxt[2] = CW'(a1c - a0c);
    tau2_nxt  = (2*TW)'(in_ch.duration) * (2*TW)'(in_ch.duration);
    sb_nxt.c2   = c2_full;
    sb_nxt.c1   = CWD'(v0w) <<< (F - TF);
    sb_nxt.c0   = CWD'(p0w) <<< (F - TF);
    sb_nxt.sing = (in_ch.duration == '0);
  end

  logic signed [CW-1:0] cc1_r [3];
  logic signed [CW-1:0] dd1_r [3];
  logic signed [CW-1:0] ee1_r [3];
  logic [TW-1:0]        tau1_r;
  logic [2*TW-1:0]      tau2_1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cc1_r    <= cc_nxt;
      dd1_r    <= dd_nxt;
      ee1_r    <= ee_nxt;
      tau1_r   <= in_ch.duration;
      tau2_1_r <= tau2_nxt;
    end
  end

  // ---------------- stage 2: products with T and T^2 in 24-bit chunks, T^3 partials
  logic signed [PW-1:0] pd_nxt [3];
  logic signed [PW-1:0] pel_nxt [3];
  logic signed [PW-1:0] peh_nxt [3];
  logic [2*TW-1:0]      t3p_nxt [2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pd_nxt[k]  = PW'(dd1_r[k]) * PW'($signed({1'b0, tau1_r}));
      pel_nxt[k] = PW'(ee1_r[k]) * PW'($signed({1'b0, tau2_1_r[TW-1:0]}));
      peh_nxt[k] = PW'(ee1_r[k]) * PW'($signed({1'b0, tau2_1_r[2*TW-1:TW]}));
    end
    for (int j = 0; j < 2; j++) begin
      t3p_nxt[j] = (2*TW)'(tau2_1_r[TW*j +: TW]) * (2*TW)'(tau1_r);
    end
  end

  logic signed [CW-1:0] cc2_r [3];
  logic signed [PW-1:0] pd2_r [3];
  logic signed [PW-1:0] pel2_r [3];
  logic signed [PW-1:0] peh2_r [3];
  logic [2*TW-1:0]      t3p2_r [2];
  logic [TW-1:0]        tau2r_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cc2_r   <= cc1_r;
      pd2_r   <= pd_nxt;
      pel2_r  <= pel_nxt;
      peh2_r  <= peh_nxt;
      t3p2_r  <= t3p_nxt;
      tau2r_r <= tau1_r;
    end
  end

  // ---------------- stage 3: numerator sums and T^3
  logic signed [NW-1:0] num_nxt [3];
  logic [3*TW-1:0]      tau3_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_nxt[k] = (NW'(cc2_r[k]) <<< (2 * TF)) + (NW'(pd2_r[k]) <<< TF)
                 + NW'(pel2_r[k]) + (NW'(peh2_r[k]) <<< TW);
    end
    tau3_nxt = (3*TW)'(t3p2_r[0]) + ((3*TW)'(t3p2_r[1]) << TW);
  end

  logic signed [NW-1:0] num3_r [3];
  logic [3*TW-1:0]      tau3_3_r;
  logic [TW-1:0]        tau3r_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num3_r   <= num_nxt;
      tau3_3_r <= tau3_nxt;
      tau3r_r  <= tau2r_r;
    end
  end

  // ---------------- stage 4: magnitudes, T^4 partials
  logic [NW-1:0]   mag_nxt [3];
  logic            neg_nxt [3];
  logic [2*TW-1:0] t4p_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_nxt[k] = num3_r[k][NW-1];
      mag_nxt[k] = neg_nxt[k] ? NW'(-num3_r[k]) : NW'(num3_r[k]);
    end
    for (int j = 0; j < 3; j++) begin
      t4p_nxt[j] = (2*TW)'(tau3_3_r[TW*j +: TW]) * (2*TW)'(tau3r_r);
    end
  end

  logic [NW-1:0]   mag4_r [3];
  logic            neg4_r [3];
  logic [2*TW-1:0] t4p4_r [3];
  logic [3*TW-1:0] tau3_4_r;
  logic [TW-1:0]   tau4r_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag4_r   <= mag_nxt;
      neg4_r   <= neg_nxt;
      t4p4_r   <= t4p_nxt;
      tau3_4_r <= tau3_3_r;
      tau4r_r  <= tau3r_r;
    end
  end

  // ---------------- stage 5: T^4
  logic [4*TW-1:0] tau4_nxt;

  always_comb begin
    tau4_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      tau4_nxt = tau4_nxt + ((4*TW)'(t4p4_r[j]) << (TW * j));
    end
  end

  logic [NW-1:0]   mag5_r [3];
  logic            neg5_r [3];
  logic [4*TW-1:0] tau4_5_r;
  logic [3*TW-1:0] tau3_5_r;
  logic [TW-1:0]   tau5r_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag5_r   <= mag4_r;
      neg5_r   <= neg4_r;
      tau4_5_r <= tau4_nxt;
      tau3_5_r <= tau3_4_r;
      tau5r_r  <= tau4r_r;
    end
  end

  // ---------------- stage 6: T^5 partials
  logic [2*TW-1:0] t5p_nxt [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      t5p_nxt[j] = (2*TW)'(tau4_5_r[TW*j +: TW]) * (2*TW)'(tau5r_r);
    end
  end

  logic [NW-1:0]   mag6_r [3];
  logic            neg6_r [3];
  logic [2*TW-1:0] t5p6_r [4];
  logic [4*TW-1:0] tau4_6_r;
  logic [3*TW-1:0] tau3_6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag6_r   <= mag5_r;
      neg6_r   <= neg5_r;
      t5p6_r   <= t5p_nxt;
      tau4_6_r <= tau4_5_r;
      tau3_6_r <= tau3_5_r;
    end
  end

  // ---------------- stage 7: T^5, operands ready for the dividers
  logic [5*TW-1:0] tau5_nxt;

  always_comb begin
    tau5_nxt = '0;
    for (int j = 0; j < 4; j++) begin
      tau5_nxt = tau5_nxt + ((5*TW)'(t5p6_r[j]) << (TW * j));
    end
  end

  logic [NW-1:0]   mag7_r [3];
  logic            neg7_r [3];
  logic [5*TW-1:0] tau5_7_r;
  logic [4*TW-1:0] tau4_7_r;
  logic [3*TW-1:0] tau3_7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag7_r   <= mag6_r;
      neg7_r   <= neg6_r;
      tau5_7_r <= tau5_nxt;
      tau4_7_r <= tau4_6_r;
      tau3_7_r <= tau3_6_r;
    end
  end

  // ---------------- quotient pipelines, denominators 2T^3, 2T^4, 2T^5
  logic [CWD-1:0] q3, q4, q5;
  logic           s3, s4, s5;

  qtc_div #(.NUM_W(NW), .SHIFT(F), .DEN_W(3*TW+1)) u_div3 (
    .clk(clk), .en(en), .num_mag(mag7_r[0]), .num_neg(neg7_r[0]),
    .den({tau3_7_r, 1'b0}), .quo(q3), .sat(s3)
  );

  qtc_div #(.NUM_W(NW), .SHIFT(TF + F), .DEN_W(4*TW+1)) u_div4 (
    .clk(clk), .en(en), .num_mag(mag7_r[1]), .num_neg(neg7_r[1]),
    .den({tau4_7_r, 1'b0}), .quo(q4), .sat(s4)
  );

  qtc_div #(.NUM_W(NW), .SHIFT(2 * TF + F), .DEN_W(5*TW+1)) u_div5 (
    .clk(clk), .en(en), .num_mag(mag7_r[2]), .num_neg(neg7_r[2]),
    .den({tau5_7_r, 1'b0}), .quo(q5), .sat(s5)
  );

  // ---------------- valid bits and start terms ride alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_nxt;
      for (int i = 1; i < LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // ---------------- result; zero duration masks the divided terms
  sb_t sb_out;
  assign sb_out = sb_r[LAT-1];

  assign out_ch.valid          = vld_r[LAT-1];
  assign out_ch.coef_pow5      = sb_out.sing ? '0 : $signed(q5);
  assign out_ch.coef_pow4      = sb_out.sing ? '0 : $signed(q4);
  assign out_ch.coef_pow3      = sb_out.sing ? '0 : $signed(q3);
  assign out_ch.coef_pow2      = sb_out.c2;
  assign out_ch.coef_pow1      = sb_out.c1;
  assign out_ch.coef_pow0      = sb_out.c0;
  assign out_ch.singular_flag  = sb_out.sing;
  assign out_ch.saturated_flag = !sb_out.sing && (s3 || s4 || s5);

endmodule

// ----- rtl/qtc_check.sv -----
// port-level checks for the quintic coefficient solver, bound to the top level
// depends on qtc_pkg and quintic_trajectory_coefficients
module qtc_check (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [qtc_pkg::COEF_W-1:0] coef_pow5,
  input logic signed [qtc_pkg::COEF_W-1:0] coef_pow4,
  input logic signed [qtc_pkg::COEF_W-1:0] coef_pow3,
  input logic                              singular_flag,
  input logic                              saturated_flag
);

  // intake follows the result side: stalls only while a result waits
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track result backpressure");

  // a waiting result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // zero duration leaves only the start terms
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && singular_flag |-> coef_pow5 == '0 && coef_pow4 == '0 && coef_pow3 == '0)
    else $error("singular result carries divided terms");

  // start terms always fit, so a singular result never clamps
  a_singular_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && singular_flag |-> !saturated_flag)
    else $error("singular result flagged as saturated");

endmodule

bind quintic_trajectory_coefficients qtc_check u_qtc_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .coef_pow5      (out_ch.coef_pow5),
  .coef_pow4      (out_ch.coef_pow4),
  .coef_pow3      (out_ch.coef_pow3),
  .singular_flag  (out_ch.singular_flag),
  .saturated_flag (out_ch.saturated_flag)
);

// ----- test/quintic_trajectory_coefficients_checker.sv -----
// result checker for the quintic trajectory coefficient solver: watches both channels,
// predicts each axis result and compares it field by field in order
// depends on qtc_pkg and qtc_if
`timescale 1ns / 1ps

module quintic_trajectory_coefficients_checker (
  input  logic clk,
  input  logic rst_n,
  qtc_in_if    in_ch,
  qtc_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   singular_seen,
  output int   saturated_seen
);

  typedef struct {
    logic [qtc_pkg::COEF_W-1:0] coef[6];
    logic                       singular;
    logic                       saturated;
  } coef_set_t;

  coef_set_t coef_q[$];
  int        mismatch_count;

  // round(num * 2^shift / den) to nearest, ties away from zero, clamped to 64 bits
  function automatic logic [63:0] rounded_quotient(input logic signed [255:0] num,
                                                   input int shift,
                                                   input logic [255:0] den,
                                                   inout bit sat);
    logic [255:0] mag, q, r;
    logic [63:0]  limit;
    bit           neg;
    neg = num[255];
    mag = neg ? -num : num;
    mag = mag << shift;
    q = mag / den;
    r = mag % den;
    if ((r << 1) >= den) q = q + 1;
    limit = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (q > {192'd0, limit}) begin
      q = {192'd0, limit};
      sat = 1'b1;
    end
    return neg ? -q[63:0] : q[63:0];
  endfunction

  // c*2^32 + d*T*2^16 + e*T^2, T in raw q8.16 units
  function automatic logic signed [255:0] boundary_sum(input longint c, input longint d,
                                                        input longint e,
                                                        input logic [23:0] tau);
    logic signed [255:0] sc, sd, se, st;
    sc = c;
    sd = d;
    se = e;
    st = tau;
    return (sc <<< 32) + ((sd * st) <<< 16) + se * st * st;
  endfunction

  function automatic coef_set_t solve_axis(input logic signed [31:0] p0_in, v0_in, a0_in,
                                            input logic signed [31:0] p1_in, v1_in, a1_in,
                                            input logic [23:0] tau);
    coef_set_t           res;
    longint              p0, v0, a0, p1, v1, a1, h;
    logic [255:0]        d3, st;
    bit                  sat;
    int                  fb;
    fb = qtc_pkg::COEF_FRAC_BITS_DEF;
    p0 = p0_in; v0 = v0_in; a0 = a0_in;
    p1 = p1_in; v1 = v1_in; a1 = a1_in;
    h = p1 - p0;
    sat = 1'b0;
    st = tau;
    res.coef[0] = '0;
    res.coef[1] = '0;
    res.coef[2] = '0;
    if (tau != 0) begin
      d3 = (st * st * st) << 1;
      res.coef[2] = rounded_quotient(boundary_sum(20 * h, -(8 * v1 + 12 * v0),
                                                  -(3 * a0 - a1), tau), fb, d3, sat);
      res.coef[1] = rounded_quotient(boundary_sum(-30 * h, 14 * v1 + 16 * v0,
                                                  3 * a0 - 2 * a1, tau), 16 + fb,
                                     d3 * st, sat);
      res.coef[0] = rounded_quotient(boundary_sum(12 * h, -6 * (v1 + v0), a1 - a0, tau),
                                     32 + fb, d3 * st * st, sat);
    end
    res.coef[3] = rounded_quotient(a0, fb, 256'd1 << 17, sat);
    res.coef[4] = rounded_quotient(v0, fb, 256'd1 << 16, sat);
    res.coef[5] = rounded_quotient(p0, fb, 256'd1 << 16, sat);
    res.singular = (tau == 0);
    res.saturated = sat;
    return res;
  endfunction

  function automatic void report_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on result %0d, %s: expected %h, got %h",
               results_seen, name, want, got);
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
    singular_seen = 0;
    saturated_seen = 0;
    mismatch_count = 0;
  end

  always @(posedge clk) begin
    coef_set_t want;
    logic [63:0] got[6];
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        coef_q.push_back(solve_axis(in_ch.start_position, in_ch.start_velocity,
                                    in_ch.start_acceleration, in_ch.end_position,
                                    in_ch.end_velocity, in_ch.end_acceleration,
                                    in_ch.duration));
      if (out_ch.valid && out_ch.ready) begin
        if (coef_q.size() == 0) begin
          fail_count++;
          report_field("unexpected result", '0, '0);
        end else begin
          want = coef_q.pop_front();
          got = '{out_ch.coef_pow5, out_ch.coef_pow4, out_ch.coef_pow3,
                  out_ch.coef_pow2, out_ch.coef_pow1, out_ch.coef_pow0};
          for (int k = 0; k < 6; k++)
            if (got[k] !== want.coef[k]) begin
              fail_count++;
              report_field($sformatf("coef_pow%0d", 5 - k), want.coef[k], got[k]);
            end
          if (out_ch.singular_flag !== want.singular) begin
            fail_count++;
            report_field("singular_flag", want.singular, out_ch.singular_flag);
          end
          if (out_ch.saturated_flag !== want.saturated) begin
            fail_count++;
            report_field("saturated_flag", want.saturated, out_ch.saturated_flag);
          end
          if (want.singular) singular_seen++;
          if (want.saturated) saturated_seen++;
        end
        results_seen++;
      end
      pending = coef_q.size();
    end
  end

endmodule

// ----- test/quintic_trajectory_coefficients_tb.sv -----
// top of the quintic trajectory coefficient testbench: clock, reset, axis stimulus,
// result-side back pressure and the verdict
// depends on qtc_pkg, qtc_if, the solver and quintic_trajectory_coefficients_checker
`timescale 1ns / 1ps

module quintic_trajectory_coefficients_tb;

  localparam int RANDOM_AXES = 1600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = qtc_pkg::FRONT_LAT + qtc_pkg::DIV_LAT + 40;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic signed [31:0] p0, v0, a0, p1, v1, a1;
    logic [23:0]        tau;
  } axis_t;

  logic clk;
  logic rst_n;
  int   fail_count, pending, results_seen, singular_seen, saturated_seen;
  int   axes_sent;
  int   cycles;

  qtc_in_if  in_ch();
  qtc_out_if out_ch();

  quintic_trajectory_coefficients dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  quintic_trajectory_coefficients_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .singular_seen (singular_seen),
    .saturated_seen(saturated_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog, sized for every transfer waiting out both sides' longest idle
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
        $display("quintic_trajectory_coefficients verification failed");
        $finish;
      end
    end
  end

  // boundary value: mostly moderate, sometimes full range or an extreme
  function automatic logic signed [31:0] pick_field();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      2, 3:    return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
      default: return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
    endcase
  endfunction

  // duration: mostly 0.25 to 8 seconds, sometimes zero, maximal or random, short ones to push into saturation
  function automatic logic [23:0] pick_duration();
    case ($urandom_range(0, 19))
      0:       return 24'd0;
      1:       return 24'($urandom_range(1, 255));
      2:       return 24'hff_ffff;
      3, 4:    return 24'($urandom());
      5, 6:    return 24'($urandom_range(256, 16383));
      default: return 24'($urandom_range(16384, 1 << 19));
    endcase
  endfunction

  // one transfer on the request channel, with a random lead-in gap if gaps is set
  task automatic send_axis(input axis_t ax, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid              <= 1'b1;
    in_ch.start_position     <= ax.p0;
    in_ch.start_velocity     <= ax.v0;
    in_ch.start_acceleration <= ax.a0;
    in_ch.end_position       <= ax.p1;
    in_ch.end_velocity       <= ax.v1;
    in_ch.end_acceleration   <= ax.a1;
    in_ch.duration           <= ax.tau;
    do @(posedge clk); while (!in_ch.ready);
    axes_sent++;
  endtask

  // result side: random stalls in stretches, plus one long hold to fill the pipeline
  initial begin
    int  taken;
    int  w;
    bit  stalls;
    bit  held;
    out_ch.ready = 1'b0;
    taken = 0;
    held = 0;
    stalls = 1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 64 == 0) stalls = $urandom_range(0, 2) != 0;
      if (taken == 200 && !held) begin
        held = 1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end
      w = stalls ? $urandom_range(0, 15) : 0;
      repeat (w) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    axis_t ax;
    axis_t corner[$];
    bit    gaps;
    axes_sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.start_position = '0;
    in_ch.start_velocity = '0;
    in_ch.start_acceleration = '0;
    in_ch.end_position = '0;
    in_ch.end_velocity = '0;
    in_ch.end_acceleration = '0;
    in_ch.duration = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners: all zero, rest-to-rest move, extremes, singular and tiny T
    corner.push_back('{0, 0, 0, 0, 0, 0, 24'd65536});
    corner.push_back('{0, 0, 0, 32'sh0001_0000, 0, 0, 24'd65536});
    corner.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                       32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 24'hff_ffff});
    corner.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 24'hff_ffff});
    corner.push_back('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                       32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 24'd1});
    corner.push_back('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                       32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 24'd1});
    corner.push_back('{32'sh0003_0000, -32'sd1, 32'sh7fff_ffff, 0, 0, 0, 24'd0});
    corner.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 24'd0});
    corner.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0, 24'd0});
    corner.push_back('{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 24'd1});
    corner.push_back('{1, 1, 1, 1, 1, 1, 24'd3});
    corner.push_back('{0, 0, 1, 0, 0, 0, 24'd3});
    corner.push_back('{0, 0, 0, 0, 0, -32'sd1, 24'h80_0000});
    corner.push_back('{32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000,
                       -32'sh0005_0000, 32'sh0000_8000, 32'sh0004_0000, 24'd131072});
    corner.push_back('{0, 32'sh5555_5555, 0, 32'shaaaa_aaaa, 0, 0, 24'h55_5555});
    corner.push_back('{32'sh1234_5678, 0, 32'shedcb_a987, 0, 32'sh0f0f_0f0f, 0,
                       24'haa_aaaa});
    corner.push_back('{0, 0, 0, 32'sh0000_0001, 0, 0, 24'h00_0100});
    corner.push_back('{0, 0, 0, 32'sh7fff_ffff, 0, 0, 24'd256});
    foreach (corner[i]) send_axis(corner[i], 1'b0);

    // random axes; idle on the request side comes and goes in stretches
    gaps = 1;
    for (int n = 0; n < RANDOM_AXES; n++) begin
      if (n % 50 == 0) gaps = $urandom_range(0, 2) != 0;
      if (n == 800) begin
        // let the pipeline drain completely before going on
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      ax.p0 = pick_field();
      ax.v0 = pick_field();
      ax.a0 = pick_field();
      ax.v1 = pick_field();
      ax.a1 = pick_field();
      // small moves dominate so most coefficients stay in range
      ax.p1 = ($urandom_range(0, 3) == 0) ? pick_field()
                                          : ax.p0 + ($signed($urandom_range(0, 20'hf_ffff))
                                                     - 32'sh0008_0000);
      ax.tau = pick_duration();
      send_axis(ax, gaps);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d axes solved, %0d with zero duration and %0d with clamped coefficients",
             results_seen, singular_seen, saturated_seen);
    $display("%0d field mismatches over %0d cycles", fail_count, cycles);
    if (fail_count == 0 && pending == 0 && results_seen == axes_sent)
      $display("quintic_trajectory_coefficients verification clean");
    else
      $display("quintic_trajectory_coefficients verification failed");
    $finish;
  end

endmodule

// ----- quintic_trajectory_coefficients.f -----
rtl/qtc_pkg.sv
rtl/qtc_if.sv
rtl/qtc_div.sv
rtl/quintic_trajectory_coefficients.sv
rtl/qtc_check.sv
test/quintic_trajectory_coefficients_checker.sv
test/quintic_trajectory_coefficients_tb.sv
